/* rtl/wrec_pkg.sv */
// shared types and constants for the weight ranked emitter culler
package wrec_pkg;

    localparam int HANDLE_W    = 16;
    localparam int WEIGHT_W    = 32;
    localparam int MAX_AWAKE_W = 7;
    localparam int RANK_W      = 6;
    localparam int CFG_DATA_W  = 7;

    localparam logic [MAX_AWAKE_W-1:0] MAX_AWAKE_RST = 7'd64;
    localparam logic                   CULL_EN_RST   = 1'b1;

    // configuration register indexes
    localparam logic CFG_MAX_AWAKE = 1'b0;
    localparam logic CFG_CULL_EN   = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PIVOT,
        ST_LATCH,
        ST_SCAN,
        ST_DRAIN,
        ST_STORE,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_WAKE = 2'd1,
        ACT_CULL = 2'd2
    } action_t;

    typedef struct packed {
        logic [HANDLE_W-1:0]        handle;
        logic signed [WEIGHT_W-1:0] weight;
        logic                       culled;
    } entry_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic                culled;
    } sorted_t;

    typedef struct packed {
        logic clear;
        logic cand_valid;
    } scan_ctl_t;

endpackage

/* rtl/wrec_rank_scan.sv */
// rank counter: counts entries that sort ahead of the pivot
module wrec_rank_scan #(
    parameter int IDX_W = 6
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wrec_pkg::scan_ctl_t                  ctl,
    input  logic signed [wrec_pkg::WEIGHT_W-1:0] pivot_weight,
    input  logic [IDX_W-1:0]                     pivot_idx,
    input  logic signed [wrec_pkg::WEIGHT_W-1:0] cand_weight,
    input  logic [IDX_W-1:0]                     cand_idx,
    output logic [IDX_W-1:0]                     rank
);

    logic [IDX_W-1:0] count_reg;
    logic [IDX_W-1:0] count_next;
    logic             ahead;

    // equal weights keep arrival order
    assign ahead = (cand_weight < pivot_weight) ||
                   ((cand_weight == pivot_weight) && (cand_idx < pivot_idx));

    always_comb
    begin
        count_next = count_reg;
        if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.cand_valid && ahead)
        begin
            count_next = count_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign rank = count_reg;

endmodule

/* rtl/weight_ranked_emitter_culler_unit.sv */
// top level of the weight ranked emitter culler
//
// Emitters of one round are loaded with start while busy is low, one request
// per cycle; busy stays low during loading. Loads past the table size are
// dropped. The request with round_end set closes the round (it is stored
// first if there is room) and raises busy.
// Ranking then walks the entry memory once per emitter: for each pivot it
// reads every loaded entry through the single read port and counts the ones
// that sort ahead of it, then writes the pivot into the sorted memory at that
// rank. Results follow on result_strobe, one per cycle in rank order, the last
// one marked by last_result. busy falls with the last result still on the
// ports, so the next round may begin loading then.
// The receiver cannot stall: every strobed result is taken in its cycle.
// Configuration writes use cfg_valid/cfg_ready (always ready); index 0 sets
// max_awake, index 1 sets culling_enabled. They are meant for idle periods.
// Reset empties the round and sets max_awake to 64 and culling enabled; the
// memories keep no reset value.
module weight_ranked_emitter_culler_unit #(
    parameter int MAX_EMITTERS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [wrec_pkg::HANDLE_W-1:0]        emitter_handle,
    input  logic signed [wrec_pkg::WEIGHT_W-1:0] cull_weight,
    input  logic                                 now_culled,
    input  logic                                 round_end,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_index,
    input  logic [wrec_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                 result_strobe,
    output logic [wrec_pkg::HANDLE_W-1:0]        out_handle,
    output logic [wrec_pkg::RANK_W-1:0]          rank,
    output logic                                 stays_awake,
    output logic [1:0]                           action,
    output logic                                 last_result
);

    localparam int IDX_W       = $clog2(MAX_EMITTERS);
    localparam int CNT_W       = $clog2(MAX_EMITTERS + 1);
    localparam int RANK_W      = wrec_pkg::RANK_W;
    localparam int MAX_AWAKE_W = wrec_pkg::MAX_AWAKE_W;

    wrec_pkg::state_t state_reg;
    wrec_pkg::state_t state_next;

    logic [CNT_W-1:0]       count_reg;
    logic [IDX_W-1:0]       i_reg;
    logic [IDX_W-1:0]       j_reg;
    logic [IDX_W-1:0]       r_reg;
    logic                   cand_valid_reg;
    logic [IDX_W-1:0]       cand_idx_reg;
    wrec_pkg::entry_t       pivot_reg;
    logic                   out_valid_reg;
    logic [IDX_W-1:0]       out_rank_reg;
    logic                   out_last_reg;
    logic [MAX_AWAKE_W-1:0] max_awake_reg;
    logic                   cull_en_reg;

    wrec_pkg::entry_t  entry_mem [MAX_EMITTERS];
    wrec_pkg::entry_t  ent_rdata_reg;
    wrec_pkg::sorted_t sorted_mem [MAX_EMITTERS];
    wrec_pkg::sorted_t sorted_rdata_reg;

    logic                accept;
    logic                full;
    logic [IDX_W-1:0]    last_idx;
    logic                ent_we;
    wrec_pkg::entry_t    ent_wdata;
    logic [IDX_W-1:0]    ent_raddr;
    logic                sorted_we;
    wrec_pkg::sorted_t   sorted_wdata;
    wrec_pkg::scan_ctl_t scan_ctl;
    logic [IDX_W-1:0]    pivot_rank;
    logic                awake;
    wrec_pkg::action_t   act;

    assign accept   = start && !busy;
    assign full     = (count_reg == CNT_W'(MAX_EMITTERS));
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wrec_pkg::ST_LOAD:
            begin
                if (accept && round_end)
                begin
                    state_next = wrec_pkg::ST_PIVOT;
                end
            end
            wrec_pkg::ST_PIVOT: state_next = wrec_pkg::ST_LATCH;
            wrec_pkg::ST_LATCH: state_next = wrec_pkg::ST_SCAN;
            wrec_pkg::ST_SCAN:
            begin
                if (j_reg == last_idx)
                begin
                    state_next = wrec_pkg::ST_DRAIN;
                end
            end
            wrec_pkg::ST_DRAIN: state_next = wrec_pkg::ST_STORE;
            wrec_pkg::ST_STORE:
            begin
                state_next = (i_reg == last_idx) ? wrec_pkg::ST_EMIT : wrec_pkg::ST_PIVOT;
            end
            wrec_pkg::ST_EMIT:
            begin
                if (r_reg == last_idx)
                begin
                    state_next = wrec_pkg::ST_LOAD;
                end
            end
            default: state_next = wrec_pkg::ST_LOAD;
        endcase
    end

    // state outputs
    always_comb
    begin
        busy                = 1'b1;
        ent_raddr           = j_reg;
        scan_ctl.clear      = 1'b0;
        scan_ctl.cand_valid = cand_valid_reg;
        sorted_we           = 1'b0;
        case (state_reg)
            wrec_pkg::ST_LOAD:  busy = 1'b0;
            wrec_pkg::ST_PIVOT:
            begin
                ent_raddr      = i_reg;
                scan_ctl.clear = 1'b1;
            end
            wrec_pkg::ST_STORE: sorted_we = 1'b1;
            default:            busy = 1'b1;
        endcase
    end

    assign ent_we              = accept && !full;
    assign ent_wdata.handle    = emitter_handle;
    assign ent_wdata.weight    = cull_weight;
    assign ent_wdata.culled    = now_culled;
    assign sorted_wdata.handle = pivot_reg.handle;
    assign sorted_wdata.culled = pivot_reg.culled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= wrec_pkg::ST_LOAD;
            count_reg      <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            r_reg          <= '0;
            cand_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cand_valid_reg <= (state_reg == wrec_pkg::ST_SCAN);
            out_valid_reg  <= (state_reg == wrec_pkg::ST_EMIT);
            case (state_reg)
                wrec_pkg::ST_LOAD:
                begin
                    if (ent_we)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    i_reg <= '0;
                    r_reg <= '0;
                end
                wrec_pkg::ST_LATCH: j_reg <= '0;
                wrec_pkg::ST_SCAN:  j_reg <= j_reg + IDX_W'(1);
                wrec_pkg::ST_STORE: i_reg <= i_reg + IDX_W'(1);
                wrec_pkg::ST_EMIT:
                begin
                    r_reg <= r_reg + IDX_W'(1);
                    if (r_reg == last_idx)
                    begin
                        count_reg <= '0;
                    end
                end
                default: j_reg <= j_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cand_idx_reg <= j_reg;
        out_rank_reg <= r_reg;
        out_last_reg <= (r_reg == last_idx);
        if (state_reg == wrec_pkg::ST_LATCH)
        begin
            pivot_reg <= ent_rdata_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_awake_reg <= wrec_pkg::MAX_AWAKE_RST;
            cull_en_reg   <= wrec_pkg::CULL_EN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                wrec_pkg::CFG_MAX_AWAKE: max_awake_reg <= cfg_data[MAX_AWAKE_W-1:0];
                wrec_pkg::CFG_CULL_EN:   cull_en_reg   <= cfg_data[0];
                default:                 cull_en_reg   <= cull_en_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // entry memory: written while loading, read while ranking
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            entry_mem[count_reg[IDX_W-1:0]] <= ent_wdata;
        end
        ent_rdata_reg <= entry_mem[ent_raddr];
    end

    // sorted memory: written at rank, read in rank order
    always_ff @(posedge clk)
    begin
        if (sorted_we)
        begin
            sorted_mem[pivot_rank] <= sorted_wdata;
        end
        sorted_rdata_reg <= sorted_mem[r_reg];
    end

    wrec_rank_scan #(
        .IDX_W(IDX_W)
    ) u_rank_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (scan_ctl),
        .pivot_weight(pivot_reg.weight),
        .pivot_idx   (i_reg),
        .cand_weight (ent_rdata_reg.weight),
        .cand_idx    (cand_idx_reg),
        .rank        (pivot_rank)
    );

    assign awake = !cull_en_reg || (MAX_AWAKE_W'(out_rank_reg) < max_awake_reg);

    always_comb
    begin
        act = wrec_pkg::ACT_NONE;
        if (awake && sorted_rdata_reg.culled)
        begin
            act = wrec_pkg::ACT_WAKE;
        end
        else if (!awake && !sorted_rdata_reg.culled)
        begin
            act = wrec_pkg::ACT_CULL;
        end
    end

    assign result_strobe = out_valid_reg;
    assign out_handle    = sorted_rdata_reg.handle;
    assign rank          = RANK_W'(out_rank_reg);
    assign stays_awake   = awake;
    assign action        = act;
    assign last_result   = out_last_reg;

endmodule

/* rtl/wrec_checker.sv */
// port-level checks for the weight ranked emitter culler, bound to the top level
module wrec_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            round_end,
    input logic                            result_strobe,
    input logic [wrec_pkg::RANK_W-1:0]     rank,
    input logic                            last_result
);

    // a load that does not close the round keeps the block open
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !round_end |=> !busy)
    else $error("busy raised by a load inside a round");

    // the closing request starts ranking
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && round_end |=> busy)
    else $error("busy not raised after round end");

    // results of a round come without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last_result |=> result_strobe)
    else $error("gap in result stream");

    // ranks count up by one
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last_result |=>
            rank == wrec_pkg::RANK_W'($past(rank) + wrec_pkg::RANK_W'(1)))
    else $error("rank sequence broken");

    // a round's first result has rank zero
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_strobe) |-> rank == '0)
    else $error("first result rank not zero");

endmodule

bind weight_ranked_emitter_culler_unit wrec_checker u_wrec_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .round_end    (round_end),
    .result_strobe(result_strobe),
    .rank         (rank),
    .last_result  (last_result)
);

/* verif/tb_weight_ranked_emitter_culler_unit.sv */
// testbench for weight_ranked_emitter_culler_unit: self-checking, predictor plus random rounds
module tb_weight_ranked_emitter_culler_unit;

    localparam int MAX_EMITTERS   = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        wrec_pkg::entry_t ent;
        logic             round_end;
        bit               hold;
    } emitter_req_t;

    typedef struct packed {
        logic [wrec_pkg::HANDLE_W-1:0] handle;
        logic [wrec_pkg::RANK_W-1:0]   rank;
        logic                          awake;
        logic [1:0]                    act;
        logic                          last;
    } verdict_t;

    logic                                 clk            = 1'b0;
    logic                                 rst_n          = 1'b0;
    logic                                 start          = 1'b0;
    logic                                 busy;
    logic [wrec_pkg::HANDLE_W-1:0]        emitter_handle = '0;
    logic signed [wrec_pkg::WEIGHT_W-1:0] cull_weight    = '0;
    logic                                 now_culled     = 1'b0;
    logic                                 round_end      = 1'b0;
    logic                                 cfg_valid      = 1'b0;
    logic                                 cfg_ready;
    logic                                 cfg_index      = wrec_pkg::CFG_MAX_AWAKE;
    logic [wrec_pkg::CFG_DATA_W-1:0]      cfg_data       = '0;
    logic                                 result_strobe;
    logic [wrec_pkg::HANDLE_W-1:0]        out_handle;
    logic [wrec_pkg::RANK_W-1:0]          rank;
    logic                                 stays_awake;
    logic [1:0]                           action;
    logic                                 last_result;

    emitter_req_t emitter_q[$];
    verdict_t     ranked_q[$];

    // predictor state
    wrec_pkg::entry_t                 round_tbl[MAX_EMITTERS];
    int unsigned                      round_cnt     = 0;
    logic [wrec_pkg::MAX_AWAKE_W-1:0] max_awake_cfg = wrec_pkg::MAX_AWAKE_RST;
    logic                             cull_en_cfg   = wrec_pkg::CULL_EN_RST;

    bit req_taken    = 1'b0;
    bit cfg_seen     = 1'b0;
    int sender_idle  = 23;
    int mismatch_cnt = 0;
    int quiet_cycles = 0;

    weight_ranked_emitter_culler_unit #(.MAX_EMITTERS(MAX_EMITTERS)) uut (.*);

    always #5 clk = ~clk;

    // store one emitter; on round end rank the round and queue its verdicts
    function automatic void load_and_rank(emitter_req_t r);
        int               order[MAX_EMITTERS];
        int               j;
        int               n;
        logic             awake;
        verdict_t         v;
        wrec_pkg::entry_t e;
        if (round_cnt < MAX_EMITTERS)
        begin
            round_tbl[round_cnt] = r.ent;
            round_cnt++;
        end
        if (!r.round_end)
            return;
        n = round_cnt;
        // stable insertion sort, equal weights keep arrival order
        for (int i = 0; i < n; i++)
        begin
            j = i;
            while (j > 0 && $signed(round_tbl[i].weight)
                            < $signed(round_tbl[order[j-1]].weight))
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        for (int i = 0; i < n; i++)
        begin
            e        = round_tbl[order[i]];
            awake    = !cull_en_cfg || (i < max_awake_cfg);
            v.handle = e.handle;
            v.rank   = i[wrec_pkg::RANK_W-1:0];
            v.awake  = awake;
            v.last   = (i == n - 1);
            if (awake && e.culled)
                v.act = wrec_pkg::ACT_WAKE;
            else if (!awake && !e.culled)
                v.act = wrec_pkg::ACT_CULL;
            else
                v.act = wrec_pkg::ACT_NONE;
            ranked_q.insert(ranked_q.size(), v);
        end
        round_cnt = 0;
    endfunction

    // driver: presents the oldest pending request, holds it until taken
    always @(negedge clk)
    begin
        if (rst_n && (!start || req_taken))
        begin
            req_taken = 1'b0;
            if (emitter_q.size() != 0 && !(emitter_q[0].hold && ranked_q.size() != 0)
                && $urandom_range(99) >= sender_idle)
            begin
                start          <= 1'b1;
                emitter_handle <= emitter_q[0].ent.handle;
                cull_weight    <= emitter_q[0].ent.weight;
                now_culled     <= emitter_q[0].ent.culled;
                round_end      <= emitter_q[0].round_end;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor: takes requests and config writes into the predictor, checks results
    always @(posedge clk)
    begin
        verdict_t got;
        verdict_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                load_and_rank(emitter_q.pop_front());
                req_taken = 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == wrec_pkg::CFG_MAX_AWAKE)
                    max_awake_cfg = cfg_data;
                else
                    cull_en_cfg = cfg_data[0];
                cfg_seen = 1'b1;
            end
            if (result_strobe)
            begin
                got = '{out_handle, rank, stays_awake, action, last_result};
                if (ranked_q.size() == 0)
                begin
                    mismatch_cnt++;
                    $display("%0t: unexpected result handle=%h rank=%0d awake=%b act=%0d last=%b",
                             $time, out_handle, rank, stays_awake, action, last_result);
                end
                else
                begin
                    want = ranked_q.pop_front();
                    if (got !== want)
                    begin
                        mismatch_cnt++;
                        $display("%0t: mismatch expected handle=%h rank=%0d awake=%b act=%0d last=%b",
                                 $time, want.handle, want.rank, want.awake, want.act, want.last);
                        $display("%0t:          actual   handle=%h rank=%0d awake=%b act=%0d last=%b",
                                 $time, got.handle, got.rank, got.awake, got.act, got.last);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any accepted request, write or result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_cfg(logic idx, logic [wrec_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_seen  = 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge clk); while (!cfg_seen);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (emitter_q.size() != 0 || ranked_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic void push_emitter(logic [15:0] h, logic [31:0] w, logic c, logic e,
                                         bit hold = 1'b0);
        emitter_req_t r;
        r.ent.handle = h;
        r.ent.weight = w;
        r.ent.culled = c;
        r.round_end  = e;
        r.hold       = hold;
        emitter_q.insert(emitter_q.size(), r);
    endfunction

    // weights bunch near zero and at the extremes so ties and sign order show up
    function automatic logic [31:0] pick_weight();
        logic [31:0] w;
        case ($urandom_range(3))
            0: w = $signed($urandom_range(6)) - 3;
            1: w = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic queue_round(int n, bit pause_first);
        for (int i = 0; i < n; i++)
            push_emitter(16'($urandom), pick_weight(), 1'($urandom_range(1)), i == n - 1,
                         pause_first && i == 0);
    endtask

    task automatic queue_small_rounds(int total);
        int n;
        int queued;
        queued = 0;
        while (queued < total)
        begin
            n = $urandom_range(1, 8);
            queue_round(n, queued == 0 || $urandom_range(4) == 0);
            queued += n;
        end
    endtask

    task automatic random_config();
        write_cfg(wrec_pkg::CFG_MAX_AWAKE,
                  wrec_pkg::CFG_DATA_W'($urandom_range(3) == 0 ? $urandom_range(64)
                                                               : $urandom_range(8)));
        write_cfg(wrec_pkg::CFG_CULL_EN, wrec_pkg::CFG_DATA_W'($urandom_range(3) != 0));
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extremes of weight and handle, ties, all three actions
        write_cfg(wrec_pkg::CFG_MAX_AWAKE, 7'd2);
        write_cfg(wrec_pkg::CFG_CULL_EN, 7'd1);
        push_emitter(16'h0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
        push_emitter(16'hFFFF, 32'h8000_0000, 1'b1, 1'b0);
        push_emitter(16'h1234, 32'h0000_0000, 1'b0, 1'b0);
        push_emitter(16'h4321, 32'h0000_0000, 1'b1, 1'b0);
        push_emitter(16'hABCD, 32'hFFFF_FFFF, 1'b1, 1'b1);
        push_emitter(16'h0F0F, 32'h0001_0000, 1'b0, 1'b1);
        settle();
        // nothing kept awake
        write_cfg(wrec_pkg::CFG_MAX_AWAKE, 7'd0);
        push_emitter(16'h00FF, 32'h0002_8000, 1'b1, 1'b0);
        push_emitter(16'h5A5A, 32'hFFFF_0000, 1'b0, 1'b0);
        push_emitter(16'hA5A5, 32'h0002_8000, 1'b0, 1'b1);
        settle();
        // culling off reports everything awake
        write_cfg(wrec_pkg::CFG_MAX_AWAKE, 7'd64);
        write_cfg(wrec_pkg::CFG_CULL_EN, 7'd0);
        push_emitter(16'h8001, 32'h0000_0005, 1'b1, 1'b0);
        push_emitter(16'h7FFE, 32'h8000_0000, 1'b0, 1'b0);
        push_emitter(16'h3C3C, 32'h7FFF_FFFF, 1'b1, 1'b1);
        settle();
        write_cfg(wrec_pkg::CFG_CULL_EN, 7'd1);
        push_emitter(16'hC3C3, 32'h0000_0001, 1'b1, 1'b0);
        push_emitter(16'h0001, 32'h0000_0001, 1'b0, 1'b0);
        push_emitter(16'hFFFE, 32'hFFFF_FFFE, 1'b1, 1'b1);
        settle();

        repeat (2)
        begin
            random_config();
            queue_small_rounds(4);
            settle();
        end

        sender_idle = 59;
        // full table closed by a stored round end
        write_cfg(wrec_pkg::CFG_MAX_AWAKE, 7'd37);
        write_cfg(wrec_pkg::CFG_CULL_EN, 7'd1);
        queue_round(MAX_EMITTERS, 1'b1);
        settle();
        repeat (2)
        begin
            random_config();
            queue_small_rounds(2);
            settle();
        end

        sender_idle = 0;
        // overflow: extra requests dropped, round end arrives on a dropped one
        write_cfg(wrec_pkg::CFG_MAX_AWAKE, 7'd63);
        queue_round(MAX_EMITTERS + 2, 1'b1);
        settle();
        random_config();
        queue_small_rounds(4);
        settle();

        repeat (8) @(posedge clk);
        if (mismatch_cnt == 0 && ranked_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
